FILE: rtl/core/mexp_pkg.sv
// mexp_pkg: widths, counts and shared types for the modular exponentiation block.
// No dependencies; imported by every module under rtl/core.
package mexp_pkg;

    // Operand and modulus width
    localparam int DATA_W = 16;
    // Exponent bits scanned per item
    localparam int EXP_BITS = 17;

    // Multiplier product and the shift-subtract reduction that follows it
    localparam int PROD_W = 2 * DATA_W;
    localparam int BITS_PER_STEP = 2;
    localparam int RED_STEPS = PROD_W / BITS_PER_STEP;
    localparam int CNT_W = $clog2(RED_STEPS);

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_MODULUS = 3'd0;
    localparam logic [DATA_W-1:0] MODULUS_RESET = 16'hFFFF;

    // Request to the shared modular multiplier
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mm_req_t;

    // Response from the shared modular multiplier
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] r;
    } mm_rsp_t;

endpackage

FILE: rtl/core/mexp_modmul.sv
// mexp_modmul: iterative (a * b) mod q; one registered multiply, then restoring
// shift-subtract reduction two product bits per cycle. Depends on mexp_pkg.
module mexp_modmul
    import mexp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DATA_W-1:0] modulus,
    input  mm_req_t           req,
    output mm_rsp_t           rsp
);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DATA_W-1:0] rem_reg, rem_next;

    logic [DATA_W:0]   t1, s1, t2, s2;
    logic [DATA_W:0]   q_ext;
    logic [PROD_W-1:0] a_ext, b_ext;

    assign q_ext = {1'b0, modulus};
    // operands widened so the full product is kept
    assign a_ext = {{(PROD_W-DATA_W){1'b0}}, req.a};
    assign b_ext = {{(PROD_W-DATA_W){1'b0}}, req.b};

    // two dependent conditional subtracts per cycle
    always_comb
    begin
        t1 = {rem_reg, prod_reg[PROD_W-1]};
        s1 = (t1 >= q_ext) ? (t1 - q_ext) : t1;
        t2 = {s1[DATA_W-1:0], prod_reg[PROD_W-2]};
        s2 = (t2 >= q_ext) ? (t2 - q_ext) : t2;
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        if (req.start)
        begin
            prod_next   = a_ext * b_ext;
            rem_next    = '0;
            cnt_next    = CNT_W'(RED_STEPS - 1);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            prod_next = prod_reg << BITS_PER_STEP;
            rem_next  = s2[DATA_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.r    = rem_reg;

`ifndef ASSERT_OFF
    // done follows the last reduction step only
    a_done_after_active: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(active_reg))
        else $error("modmul done without an active reduction");

    // remainder stays reduced while working with a nonzero modulus
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && $past(active_reg) && modulus != '0) |-> rem_reg < modulus)
        else $error("modmul remainder not below modulus");

    // no new request while a reduction is running
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !req.start)
        else $error("modmul request while busy");
`endif

endmodule

FILE: rtl/core/mexp_seq.sv
// mexp_seq: square-and-multiply sequencer; walks exponent bits LSB first and
// drives the shared modular multiplier. Depends on mexp_pkg.
module mexp_seq
    import mexp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DATA_W-1:0]   base,
    input  logic [EXP_BITS-1:0] exponent,
    input  logic                q_zero,
    input  mm_rsp_t             mm_rsp,
    output mm_req_t             mm_req,
    output logic                busy,
    output logic [DATA_W-1:0]   result,
    output logic                done
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_SQR  = 4'b1000
    } seq_state_t;

    seq_state_t          state_reg, state_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   base_reg, base_next;
    logic                exp_nz_reg, exp_nz_next;
    logic [DATA_W-1:0]   result_reg, result_next;
    logic                done_reg, done_next;
    mm_req_t             req_reg, req_next;

    always_comb
    begin
        state_next  = state_reg;
        exp_next    = exp_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        exp_nz_next = exp_nz_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        req_next    = '{start: 1'b0, a: req_reg.a, b: req_reg.b};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    exp_next    = exponent;
                    acc_next    = DATA_W'(1);
                    base_next   = base;
                    exp_nz_next = (exponent != '0);
                    state_next  = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (exp_reg == '0)
                begin
                    // a zero modulus gives zero unless the exponent was zero
                    result_next = (q_zero && exp_nz_reg) ? '0 : acc_reg;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (exp_reg[0])
                begin
                    req_next   = '{start: 1'b1, a: acc_reg, b: base_reg};
                    state_next = ST_ACC;
                end
                else
                begin
                    req_next   = '{start: 1'b1, a: base_reg, b: base_reg};
                    state_next = ST_SQR;
                end
            end
            ST_ACC:
            begin
                if (mm_rsp.done)
                begin
                    acc_next    = mm_rsp.r;
                    exp_next[0] = 1'b0;
                    state_next  = ST_STEP;
                end
            end
            ST_SQR:
            begin
                if (mm_rsp.done)
                begin
                    base_next  = mm_rsp.r;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        exp_nz_reg <= exp_nz_next;
        result_reg <= result_next;
    end

    assign mm_req = req_reg;
    assign busy   = (state_reg != ST_IDLE);
    assign result = result_reg;
    assign done   = done_reg;

`ifndef ASSERT_OFF
    // a multiply is only launched from the decision state
    a_req_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        req_reg.start |-> ($past(state_reg) == ST_STEP))
        else $error("multiply launched outside decision state");

    // multiplier answers only while a wait state is pending
    a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_rsp.done |-> (state_reg == ST_ACC || state_reg == ST_SQR))
        else $error("multiplier response with no wait pending");

    // state register stays one-hot
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");
`endif

endmodule

FILE: rtl/core/modular_exponentiation_top.sv
// modular_exponentiation_top: base^exponent mod q with an APB modulus register.
// Depends on mexp_pkg, mexp_seq and mexp_modmul.
//
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+---------------------------------
// command   | start & !busy               | base[15:0], exponent[16:0]
// result    | done (one-cycle strobe)     | result[15:0]
// config    | psel & penable & pwrite     | paddr[2:0], pwdata[31:0] (modulus)
//
// Operation: each modular multiply is one registered multiply followed by the
// shift-subtract reduction (two product bits per cycle in the shared unit); an item
// runs one multiply per set exponent bit and one squaring per bit below the
// highest set bit. A zero exponent needs no multiply.
// Reset: asynchronous, active low; modulus returns to 65535, sequencer to idle.
// Stalls: busy stays high from the accepted start until the result strobe; the
// receiver cannot stall, so the result transfer completes in its strobe cycle.
module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_W-1:0]     base,
    input  logic [EXP_BITS-1:0]   exponent,
    // result channel
    output logic                  done,
    output logic [DATA_W-1:0]     result,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DATA_W-1:0] modulus_reg, modulus_next;
    logic              cfg_wr;
    mm_req_t           mm_req;
    mm_rsp_t           mm_rsp;

    // ---------------- configuration register ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MODULUS);

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_wr)
        begin
            modulus_next = pwdata[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // read back; unmapped addresses read zero
    assign prdata = (paddr == ADDR_MODULUS) ?
                    {{(APB_DATA_W-DATA_W){1'b0}}, modulus_reg} : '0;

    // ---------------- sequencer ----------------
    mexp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .base     (base),
        .exponent (exponent),
        .q_zero   (modulus_reg == '0),
        .mm_rsp   (mm_rsp),
        .mm_req   (mm_req),
        .busy     (busy),
        .result   (result),
        .done     (done)
    );

    // ---------------- shared modular multiplier ----------------
    mexp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

`ifndef ASSERT_OFF
    // an accepted command makes the block busy on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // busy drops exactly when the result transfer is presented
    a_fell_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a result only follows a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding command");
`endif

endmodule

FILE: tb/modular_exponentiation_checker.sv
`timescale 1ns / 100ps
// modular_exponentiation_checker: watches the command, result and register ports of
// modular_exponentiation_top, predicts each result and compares. Depends on mexp_pkg.
module modular_exponentiation_checker
    import mexp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [DATA_W-1:0]     base,
    input  logic [EXP_BITS-1:0]   exponent,
    input  logic                  done,
    input  logic [DATA_W-1:0]     result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    pending,
    output int                    fail_count
);

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   base;
        logic [EXP_BITS-1:0] exponent;
        logic [DATA_W-1:0]   modulus;
    } expected_power_t;

    expected_power_t   expected_powers[$];
    logic [DATA_W-1:0] modulus_reg;

    // right-to-left square-and-multiply; a zero modulus gives zero unless the exponent is zero
    function automatic logic [DATA_W-1:0] power_mod(input logic [DATA_W-1:0] b_in,
                                                    input logic [EXP_BITS-1:0] e,
                                                    input logic [DATA_W-1:0] q);
        logic [PROD_W-1:0] acc;
        logic [PROD_W-1:0] sq;
        acc = 1;
        sq  = {{(PROD_W-DATA_W){1'b0}}, b_in};
        for (int i = 0; i < EXP_BITS; i++)
        begin
            if (e[i])
                acc = (q == 0) ? '0 : (acc * sq) % q;
            sq = (q == 0) ? '0 : (sq * sq) % q;
        end
        return acc[DATA_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        expected_power_t head;
        expected_power_t entry;
        if (!rst_n)
        begin
            modulus_reg = MODULUS_RESET;
            expected_powers.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // result first: a new command can be taken in the strobe cycle
            if (done)
            begin
                if (expected_powers.size() == 0)
                begin
                    $display("%0t: result %0d with no command outstanding", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    head = expected_powers.pop_front();
                    if (result !== head.value)
                    begin
                        $display("%0t: result mismatch: expected %0d, actual %0d (base %0d exp %0d mod %0d)",
                                 $time, head.value, result, head.base, head.exponent,
                                 head.modulus);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                entry.base     = base;
                entry.exponent = exponent;
                entry.modulus  = modulus_reg;
                entry.value    = power_mod(base, exponent, modulus_reg);
                expected_powers.push_back(entry);
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_MODULUS)
                modulus_reg = pwdata[DATA_W-1:0];
            pending <= expected_powers.size();
        end
    end

endmodule

FILE: tb/modular_exponentiation_top_tb.sv
`timescale 1ns / 100ps
// modular_exponentiation_top_tb: stimulus and verdict for modular_exponentiation_top.
// Depends on mexp_pkg, the RTL under rtl/core and modular_exponentiation_checker.
module modular_exponentiation_top_tb;
    import mexp_pkg::*;

    // Byte address 4 maps to no register; writes there must leave the modulus alone.
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASE_ITEMS  = 125;
    // Cycles without any transfer before the run is declared hung. The longest wait
    // is the slowest item, plus a short random sender wait and a register write.
    localparam int STALL_LIMIT  = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [DATA_W-1:0]     base;
    logic [EXP_BITS-1:0]   exponent;
    logic                  done;
    logic [DATA_W-1:0]     result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int gap_pct;
    int stall_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    modular_exponentiation_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .base     (base),
        .exponent (exponent),
        .done     (done),
        .result   (result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // The checker sees every port of the block but prdata and owns all prediction.
    modular_exponentiation_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .base       (base),
        .exponent   (exponent),
        .done       (done),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Watchdog: any command, result or register transfer resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pwrite))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("modular_exponentiation_top test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // One command transfer. Payload is held from the first cycle; each cycle start
    // is raised at random so the sender idles gap_pct cycles in a hundred.
    // Returns at the edge that took the transfer, with start still high.
    task automatic send_power(input logic [DATA_W-1:0] b, input logic [EXP_BITS-1:0] e);
        base     <= b;
        exponent <= e;
        start    <= ($urandom_range(99) >= gap_pct);
        // start and busy read here are their values before this edge
        @(posedge clk);
        while (!(start && !busy))
        begin
            start <= ($urandom_range(99) >= gap_pct);
            @(posedge clk);
        end
    endtask

    // Stop issuing and wait until every predicted result has come back.
    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
    endtask

    // Two-phase register write; the block must be idle. The leading edge keeps a
    // back-to-back write from lowering and raising psel in the same step.
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [DATA_W-1:0]   q;
        logic [DATA_W-1:0]   b;
        logic [EXP_BITS-1:0] e;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        base     <= '0;
        exponent <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        gap_pct  = 30;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: runs first on the reset modulus (65535) ----
        send_power(16'h0000, 17'h00000);      // zero exponent
        send_power(16'hFFFF, 17'h00000);
        send_power(16'h0000, 17'h00001);
        send_power(16'h0000, 17'h1FFFF);
        send_power(16'hFFFF, 17'h1FFFF);      // base equal to modulus
        send_power(16'hFFFF, 17'h00001);
        send_power(16'h0001, 17'h1FFFF);
        send_power(16'h0002, 17'h00010);      // 2^16 wraps to 1
        send_power(16'hFFFE, 17'h10000);      // only the top exponent bit
        send_power(16'hAAAA, 17'h15555);
        send_power(16'h5555, 17'h0AAAA);
        drain;
        // unmapped address: modulus must stay 65535
        write_reg(ADDR_UNMAPPED, 32'h0000_0007);
        send_power(16'h8000, 17'h00003);
        drain;
        // modulus of one, upper write data bits set: zero exponent still gives 1
        write_reg(ADDR_MODULUS, 32'hFFFF_0001);
        send_power(16'h0005, 17'h00000);
        send_power(16'hFFFF, 17'h1FFFF);
        drain;
        // zero modulus: results are zero except for a zero exponent
        write_reg(ADDR_MODULUS, 32'h0000_0000);
        send_power(16'h0007, 17'h00000);
        send_power(16'h0007, 17'h00005);
        send_power(16'hFFFF, 17'h1FFFF);
        drain;
        // unreduced base well above a tiny modulus
        write_reg(ADDR_MODULUS, 32'h0000_0002);
        send_power(16'hFFFF, 17'h00003);
        send_power(16'h0002, 17'h00001);
        drain;
        // prime modulus; Fermat gives 1
        write_reg(ADDR_MODULUS, 32'h0000_FFF1);
        send_power(16'hFFFF, 17'd65520);
        send_power(16'h0003, 17'h1FFFF);
        drain;

        // ---- random: one modulus per phase, sender idling 30% / 88% / none ----
        for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++)
        begin
            case (p)
                0:       q = 16'hFFFF;
                1:       q = 16'h0001;
                3:       q = 16'hFFF1;
                4:       q = 16'h0002;
                6:       q = 16'h8000;
                default: q = DATA_W'($urandom_range(1, 65535));
            endcase
            drain;
            write_reg(ADDR_MODULUS, {DATA_W'($urandom_range(0, 65535)), q});
            for (int k = p * PHASE_ITEMS; k < (p + 1) * PHASE_ITEMS; k++)
            begin
                gap_pct = (k < RANDOM_ITEMS / 3) ? 30 : (k < 2 * RANDOM_ITEMS / 3) ? 88 : 0;
                // bias the base toward values around the modulus
                case ($urandom_range(9))
                    0:       b = 16'h0000;
                    1:       b = 16'hFFFF;
                    2:       b = q - 16'd1;
                    3:       b = q;
                    4:       b = DATA_W'($urandom_range(0, q));
                    default: b = DATA_W'($urandom_range(0, 65535));
                endcase
                case ($urandom_range(9))
                    0:       e = '0;
                    1:       e = EXP_BITS'($urandom_range(0, 15));
                    2:       e = 17'h1 << $urandom_range(0, EXP_BITS - 1);
                    3:       e = 17'h1FFFF;
                    default: e = EXP_BITS'($urandom_range(0, 131071));
                endcase
                send_power(b, e);
            end
        end
        drain;

        // settle: the block should be silent from here on
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("modular_exponentiation_top test passed");
        else
            $display("modular_exponentiation_top test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mexp_pkg.sv
rtl/core/mexp_modmul.sv
rtl/core/mexp_seq.sv
rtl/core/modular_exponentiation_top.sv
tb/modular_exponentiation_checker.sv
tb/modular_exponentiation_top_tb.sv
